// ----- sv/annexb_nal_unit_splitter_macros.svh -----
// assertion helpers used by the splitter output module
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define ANX_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("splitter check failed");

// next-cycle implication, clocked on aclk, off during reset
`define ANX_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("splitter check failed");

`endif

// ----- sv/annexb_pkg.sv -----
`default_nettype none
package annexb_pkg;

    localparam int NAL_SIZE_BITS = 24;
    localparam int SAMPLE_BITS   = 32;
    localparam int SUM_BITS      = SAMPLE_BITS + 1;
    localparam int MAX_RESULTS   = 3;
    localparam int SLOT_BITS     = $clog2(MAX_RESULTS);
    localparam int COUNT_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int PREFIX_BYTES  = 4;
    localparam int START_ZEROS   = 2;

    typedef logic [NAL_SIZE_BITS-1:0] size_t;
    typedef logic [4:0]               nal_type_t;

    localparam size_t     SIZE_LIMIT  = {NAL_SIZE_BITS{1'b1}};
    localparam nal_type_t TYPE_SLICE  = 5'd1;
    localparam nal_type_t TYPE_IDR    = 5'd5;
    localparam nal_type_t TYPE_SPS    = 5'd7;
    localparam nal_type_t TYPE_PPS    = 5'd8;
    localparam logic [7:0] START_BYTE = 8'h01;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_NAL_END  = 2'd1,
        KIND_UNIT_END = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_unit;
    } in_item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             payload_byte;
        size_t                  zeros_before;
        logic                   first_of_nal;
        nal_type_t              nal_type;
        size_t                  nal_length;
        logic                   nal_included;
        logic [SAMPLE_BITS-1:0] sample_size;
        logic                   has_vcl;
        logic                   size_overflow;
        logic                   last;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]         count;
        out_item_t [MAX_RESULTS-1:0]   slot;
    } result_set_t;

    typedef struct packed {
        logic                   nal_open;
        size_t                  zero_run;
        size_t                  count;
        nal_type_t              ntype;
        logic [SAMPLE_BITS-1:0] total;
        logic                   vcl;
        logic                   ovf;
    } parse_state_t;

endpackage
`default_nettype wire

// ----- sv/annexb_parse.sv -----
`default_nettype none
module annexb_parse
    import annexb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_item,
    input  wire logic        load_ready,
    output logic             load,
    output result_set_t      load_set
);

    typedef struct packed {
        logic         fire;
        out_item_t    item;
        parse_state_t st;
    } nal_end_t;

    function automatic nal_end_t end_nal(parse_state_t st);
        nal_end_t            r;
        logic                incl;
        logic [SUM_BITS-1:0] sum;
        r      = '0;
        r.st   = st;
        r.fire = st.nal_open && (st.count != '0);
        incl   = (st.ntype != TYPE_SPS) && (st.ntype != TYPE_PPS);
        sum    = SUM_BITS'(st.total) + SUM_BITS'(st.count) + SUM_BITS'(PREFIX_BYTES);
        if (r.fire) begin
            if ((st.ntype == TYPE_SLICE) || (st.ntype == TYPE_IDR)) begin
                r.st.vcl = 1'b1;
            end
            if (incl) begin
                if (sum[SAMPLE_BITS]) begin
                    r.st.total = {SAMPLE_BITS{1'b1}};
                    r.st.ovf   = 1'b1;
                end else begin
                    r.st.total = sum[SAMPLE_BITS-1:0];
                end
            end
            r.item.kind          = KIND_NAL_END;
            r.item.nal_type      = st.ntype;
            r.item.nal_length    = st.count;
            r.item.nal_included  = incl;
            r.item.sample_size   = r.st.total;
            r.item.has_vcl       = r.st.vcl;
            r.item.size_overflow = r.st.ovf;
            r.st.count           = '0;
            r.st.ntype           = '0;
        end
        return r;
    endfunction

    logic         in_valid_reg;
    in_item_t     in_item_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_set_t  set_next;

    assign load    = in_valid_reg && load_ready;
    assign s_ready = !in_valid_reg || load_ready;

    always_comb begin
        parse_state_t          st;
        parse_state_t          st_pre;
        nal_end_t              er;
        out_item_t             it;
        logic [7:0]            b;
        logic                  is_start;
        logic                  last_in;
        logic [NAL_SIZE_BITS:0] add_sum;
        logic [COUNT_BITS-1:0] n;
        st       = state_reg;
        st_pre   = state_reg;
        set_next = '0;
        n        = '0;
        b        = in_item_reg.data_byte;
        last_in  = in_item_reg.last_of_unit;
        is_start = (b == START_BYTE) && (st.zero_run >= size_t'(START_ZEROS));
        add_sum  = {1'b0, st.count} + {1'b0, st.zero_run} + (NAL_SIZE_BITS+1)'(1);
        it       = '0;
        if (b == 8'd0) begin
            if (st.zero_run != SIZE_LIMIT) begin
                st.zero_run = st.zero_run + size_t'(1);
            end
        end else if (is_start) begin
            st = state_reg;
        end else if (!st.nal_open) begin
            st.zero_run = '0;
        end else begin
            it.kind         = KIND_PAYLOAD;
            it.payload_byte = b;
            it.zeros_before = st.zero_run;
            if (st.count == '0) begin
                it.first_of_nal = 1'b1;
                st.ntype = (st.zero_run != '0) ? nal_type_t'(0) : b[4:0];
            end
            if (add_sum[NAL_SIZE_BITS]) begin
                st.count = SIZE_LIMIT;
                st.ovf   = 1'b1;
            end else begin
                st.count = add_sum[NAL_SIZE_BITS-1:0];
            end
            st.zero_run = '0;
            set_next.slot[n[SLOT_BITS-1:0]] = it;
            n = n + COUNT_BITS'(1);
        end
        er = end_nal(is_start ? st_pre : st);
        if (is_start || last_in) begin
            st = er.st;
            if (er.fire) begin
                set_next.slot[n[SLOT_BITS-1:0]] = er.item;
                n = n + COUNT_BITS'(1);
            end
        end
        if (is_start) begin
            st.nal_open = 1'b1;
            st.count    = '0;
            st.ntype    = '0;
            st.zero_run = '0;
        end
        if (last_in) begin
            it               = '0;
            it.kind          = KIND_UNIT_END;
            it.sample_size   = st.total;
            it.has_vcl       = st.vcl;
            it.size_overflow = st.ovf;
            set_next.slot[n[SLOT_BITS-1:0]] = it;
            n  = n + COUNT_BITS'(1);
            st = '0;
        end
        if (n != '0) begin
            set_next.slot[SLOT_BITS'(n - COUNT_BITS'(1))].last = 1'b1;
        end
        set_next.count = n;
        state_next     = st;
    end

    assign load_set = set_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

// ----- sv/annexb_out.sv -----
`default_nettype none
`include "annexb_nal_unit_splitter_macros.svh"
module annexb_out
    import annexb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire result_set_t load_set,
    output logic             load_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_item
);

    out_item_t [MAX_RESULTS-1:0] slot_reg;
    logic [SLOT_BITS-1:0]        head_reg;
    logic [COUNT_BITS-1:0]       remaining_reg;

    assign m_valid    = remaining_reg != '0;
    assign m_item     = slot_reg[head_reg];
    assign load_ready = (remaining_reg == '0) ||
                        ((remaining_reg == COUNT_BITS'(1)) && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            remaining_reg <= '0;
        end else if (load) begin
            head_reg      <= '0;
            remaining_reg <= load_set.count;
        end else if (m_valid && m_ready) begin
            head_reg      <= head_reg + SLOT_BITS'(1);
            remaining_reg <= remaining_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= load_set.slot;
        end
    end

    `ANX_ASSERT_NOW(a_last_is_final, m_valid && m_item.last, remaining_reg == COUNT_BITS'(1))
    `ANX_ASSERT_NEXT(a_load_shows, load && (load_set.count != '0), m_valid && (head_reg == '0))
    `ANX_ASSERT_NEXT(a_more_follow, m_valid && m_ready && !m_item.last, m_valid)

endmodule
`default_nettype wire

// ----- sv/annexb_nal_unit_splitter.sv -----
// annexb_nal_unit_splitter: splits an annex b access unit into nal units
// input channel s_valid/s_ready/s_item carries one stream byte per item,
// with last_of_unit set on the final byte of the access unit
// output channel m_valid/m_ready/m_item gives payload bytes (with the count
// of held zeros before each), nal end records and an access unit end record
// one input byte gives zero to three output items; m_item.last marks the
// final item caused by a byte
// path: a taken byte sits in the input register, then its items are loaded
// into the result register; throughput while m_ready is high: one byte per
// cycle while each byte gives at most one item; a byte that gives more items
// holds the input while the single result register is emptied one item a cycle
// reset: aresetn low at a clock edge clears the parse state, the input valid flag
// and the result count (held data stays); outputs go idle
// stall: while m_ready is low the result register holds and the input
// register fills, then s_ready drops; no item is lost
`default_nettype none
module annexb_nal_unit_splitter
    import annexb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_item
);

    logic        load;
    logic        load_ready;
    result_set_t load_set;

    annexb_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .load_ready (load_ready),
        .load       (load),
        .load_set   (load_set)
    );

    annexb_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .load_set   (load_set),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule
`default_nettype wire

// ----- verif/tb_annexb_nal_unit_splitter.sv -----
`timescale 1ns / 100ps
module tb_annexb_nal_unit_splitter;
    import annexb_pkg::*;

    localparam int ITEM_TARGET  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PERCENT = 12;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    bit        steady = 1'b0;
    int        failures = 0;
    int        quiet_cycles = 0;

    out_item_t results_due[$];
    in_item_t  unit_bytes[$];
    stim_row_t directed_rows[$];

    // predictor state
    logic              in_nal;
    size_t             held_zeros;
    size_t             nal_bytes;
    nal_type_t         nal_kind;
    logic [31:0]       au_total;
    logic              au_vcl;
    logic              au_ovf;

    annexb_nal_unit_splitter DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void clear_parse_state();
        in_nal     = 1'b0;
        held_zeros = '0;
        nal_bytes  = '0;
        nal_kind   = '0;
        au_total   = '0;
        au_vcl     = 1'b0;
        au_ovf     = 1'b0;
    endfunction

    function automatic void close_nal();
        out_item_t   r;
        logic        incl;
        logic [32:0] sum;
        if (!in_nal || nal_bytes == '0) return;
        incl = (nal_kind != TYPE_SPS && nal_kind != TYPE_PPS);
        if (nal_kind == TYPE_SLICE || nal_kind == TYPE_IDR) au_vcl = 1'b1;
        if (incl) begin
            sum = {1'b0, au_total} + 33'(PREFIX_BYTES) + 33'(nal_bytes);
            if (sum[32]) begin
                au_total = '1;
                au_ovf   = 1'b1;
            end else begin
                au_total = sum[31:0];
            end
        end
        r = '0;
        r.kind          = KIND_NAL_END;
        r.nal_type      = nal_kind;
        r.nal_length    = nal_bytes;
        r.nal_included  = incl;
        r.sample_size   = au_total;
        r.has_vcl       = au_vcl;
        r.size_overflow = au_ovf;
        results_due.push_back(r);
        nal_bytes = '0;
        nal_kind  = '0;
    endfunction

    function automatic void split_byte(in_item_t it);
        out_item_t              r;
        logic [NAL_SIZE_BITS:0] sum;
        int                     queued;
        queued = results_due.size();
        if (it.data_byte == 8'h00) begin
            if (held_zeros != SIZE_LIMIT) held_zeros = held_zeros + 1'b1;
        end else if (it.data_byte == START_BYTE && held_zeros >= START_ZEROS) begin
            close_nal();
            in_nal     = 1'b1;
            nal_bytes  = '0;
            nal_kind   = '0;
            held_zeros = '0;
        end else if (!in_nal) begin
            held_zeros = '0;
        end else begin
            r = '0;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = it.data_byte;
            r.zeros_before = held_zeros;
            if (nal_bytes == '0) begin
                r.first_of_nal = 1'b1;
                nal_kind = (held_zeros != '0) ? nal_type_t'(0) : it.data_byte[4:0];
            end
            sum = {1'b0, nal_bytes} + {1'b0, held_zeros} + 1'b1;
            if (sum > SIZE_LIMIT) begin
                nal_bytes = SIZE_LIMIT;
                au_ovf    = 1'b1;
            end else begin
                nal_bytes = sum[NAL_SIZE_BITS-1:0];
            end
            results_due.push_back(r);
            held_zeros = '0;
        end
        if (it.last_of_unit) begin
            close_nal();
            r = '0;
            r.kind          = KIND_UNIT_END;
            r.sample_size   = au_total;
            r.has_vcl       = au_vcl;
            r.size_overflow = au_ovf;
            results_due.push_back(r);
            clear_parse_state();
        end
        if (results_due.size() > queued) begin
            r = results_due.pop_back();
            r.last = 1'b1;
            results_due.push_back(r);
        end
    endfunction

    function automatic stim_row_t row(logic [7:0] b, logic l = 1'b0);
        stim_row_t sr;
        sr.item  = {b, l};
        sr.typed = 1'b0;
        sr.want  = '0;
        return sr;
    endfunction

    function automatic stim_row_t checked_row(logic [7:0] b, logic l, out_item_t want);
        stim_row_t sr;
        sr       = row(b, l);
        sr.typed = 1'b1;
        sr.want  = want;
        return sr;
    endfunction

    function automatic out_item_t payload_item(logic [7:0] b, size_t zeros, logic first);
        out_item_t r;
        r = '0;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.zeros_before = zeros;
        r.first_of_nal = first;
        r.last         = 1'b1;
        return r;
    endfunction

    function automatic out_item_t empty_unit_end();
        out_item_t r;
        r = '0;
        r.kind = KIND_UNIT_END;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [7:0] body_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) return 8'h00;
        if (roll < 35) return START_BYTE;
        return 8'($urandom_range(255));
    endfunction

    function automatic void add_byte(logic [7:0] b);
        unit_bytes.push_back({b, 1'b0});
    endfunction

    function automatic void build_unit();
        in_item_t  tail;
        nal_type_t t;
        int        len;
        unit_bytes.delete();
        if ($urandom_range(99) < 15) begin
            // noise unit
            repeat ($urandom_range(6, 1)) add_byte(body_byte());
        end else begin
            repeat ($urandom_range(2)) add_byte(8'($urandom_range(255, 2)));
            repeat ($urandom_range(4, 1)) begin
                repeat ($urandom_range(4, 2)) add_byte(8'h00);
                add_byte(START_BYTE);
                case ($urandom_range(7))
                    0: t = TYPE_SLICE;
                    1: t = TYPE_IDR;
                    2: t = TYPE_SPS;
                    3: t = TYPE_PPS;
                    default: t = 5'($urandom_range(31));
                endcase
                if ($urandom_range(19) == 0) add_byte(8'h00);
                else add_byte({3'($urandom_range(7)), t});
                len = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
                repeat (len) add_byte(body_byte());
                if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) add_byte(8'h00);
            end
            // broken sequence
            if ($urandom_range(9) == 0) unit_bytes.delete($urandom_range(unit_bytes.size() - 1));
        end
        if (unit_bytes.size() == 0) add_byte(body_byte());
        tail = unit_bytes.pop_back();
        tail.last_of_unit = 1'b1;
        unit_bytes.push_back(tail);
    endfunction

    task automatic drive_byte(in_item_t it);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t unexpected item: expected none, got kind %0h", $time, m_item.kind);
                failures++;
            end else begin
                want = results_due.pop_front();
                compare_field("kind", want.kind, m_item.kind);
                compare_field("payload_byte", want.payload_byte, m_item.payload_byte);
                compare_field("zeros_before", want.zeros_before, m_item.zeros_before);
                compare_field("first_of_nal", want.first_of_nal, m_item.first_of_nal);
                compare_field("nal_type", want.nal_type, m_item.nal_type);
                compare_field("nal_length", want.nal_length, m_item.nal_length);
                compare_field("nal_included", want.nal_included, m_item.nal_included);
                compare_field("sample_size", want.sample_size, m_item.sample_size);
                compare_field("has_vcl", want.has_vcl, m_item.has_vcl);
                compare_field("size_overflow", want.size_overflow, m_item.size_overflow);
                compare_field("last", want.last, m_item.last);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int  sent;
        bit  paused;
        clear_parse_state();

        directed_rows.push_back(checked_row(8'h55, 1'b1, empty_unit_end()));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(START_BYTE));
        directed_rows.push_back(checked_row(8'h67, 1'b0, payload_item(8'h67, '0, 1'b1)));
        directed_rows.push_back(checked_row(8'hFF, 1'b0, payload_item(8'hFF, '0, 1'b0)));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(START_BYTE));
        directed_rows.push_back(row(8'h65));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(checked_row(8'h80, 1'b0, payload_item(8'h80, 24'd2, 1'b0)));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(START_BYTE));
        directed_rows.push_back(row(START_BYTE));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(START_BYTE));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'h41));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(START_BYTE));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(START_BYTE));
        directed_rows.push_back(row(8'h21));
        directed_rows.push_back(row(8'h7F, 1'b1));
        directed_rows.push_back(checked_row(8'h00, 1'b1, empty_unit_end()));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            drive_byte(directed_rows[i].item);
            split_byte(directed_rows[i].item);
            if (directed_rows[i].typed) begin
                void'(results_due.pop_back());
                results_due.push_back(directed_rows[i].want);
            end
        end

        // hold off until the directed results are all out
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);

        sent   = 0;
        paused = 1'b0;
        while (sent < ITEM_TARGET) begin
            build_unit();
            steady = (sent >= 150 && sent < 250);
            foreach (unit_bytes[i]) begin
                drive_byte(unit_bytes[i]);
                split_byte(unit_bytes[i]);
            end
            sent += unit_bytes.size();
            if (!paused && sent >= 300) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (results_due.size() != 0);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
